@@ src/mfx_pkg.sv @@
// ----------------------------------------------------------------------------
// Manchester frame transmitter package
// Shared types, request codes, frame constants and the Manchester word encoder.
// ----------------------------------------------------------------------------
package mfx_pkg;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_START  = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SYNC       = 2'd0;
   localparam logic [1:0] CSR_START_FLAG = 2'd1;
   localparam logic [1:0] CSR_END_FLAG   = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned BYTE_W      = 8;

   // Manchester word geometry.
   localparam int unsigned HALF_BITS_PER_WORD = 20;
   localparam int unsigned HALF_CNT_W         = 5;
   localparam logic [HALF_BITS_PER_WORD-1:0] IDLE_WORD = 20'hAAAAA;
   localparam logic [HALF_BITS_PER_WORD-1:0] ONES_WORD = 20'hFFFFF;

   // Frame layout: three preamble bytes, sync, start flag, payload, end flag.
   localparam logic [BYTE_W-1:0] PREAMBLE_BYTE  = 8'hAA;
   localparam int unsigned       FRAME_OVERHEAD = 6;
   localparam int unsigned       POS_SYNC       = 3;
   localparam int unsigned       POS_START_FLAG = 4;
   localparam int unsigned       POS_PAYLOAD    = 5;

   // One result of the block.
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_payload_type;

   // Builds the 20 half-bit word: start symbol in the top bits, data MSB first
   // with a one as low-high and a zero as high-low, stop symbol at the bottom.
   function automatic logic [HALF_BITS_PER_WORD-1:0] encode_word(input logic [BYTE_W-1:0] b);
      logic [HALF_BITS_PER_WORD-1:0] w;
      w        = '0;
      w[19:18] = 2'b10;
      for (int i = 0; i < 8; i++) begin
         w[17-2*i -: 2] = b[7-i] ? 2'b10 : 2'b01;
      end
      w[1:0] = 2'b01;
      return w;
   endfunction

endpackage

@@ src/mfx_channels.sv @@
// ----------------------------------------------------------------------------
// Manchester frame transmitter channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface mfx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] payload_byte;

   modport source (output valid, output req_type, output payload_byte, input ready);
   modport sink   (input valid, input req_type, input payload_byte, output ready);
endinterface

interface mfx_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic rejected;

   modport source (output valid, output line_level, output busy_res, output rejected,
                   input ready);
   modport sink   (input valid, input line_level, input busy_res, input rejected,
                   output ready);
endinterface

@@ src/mfx_store.sv @@
// ----------------------------------------------------------------------------
// Payload store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module mfx_store #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import mfx_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mfx_outq.sv @@
// ----------------------------------------------------------------------------
// Response buffer
// Output register plus one skid entry so that requests keep flowing while a
// response waits for the sink.
// ----------------------------------------------------------------------------
module mfx_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mfx_pkg::rsp_payload_type push_data,
   output logic                     push_ready,
   mfx_rsp_if.source                rsp_ch
);
   import mfx_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            taken;

   assign taken      = out_valid_ff && rsp_ch.ready;
   assign push_ready = !skid_valid_ff;

   // Next state of the two entries.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (taken) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || taken) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.line_level = out_data_ff.line_level;
   assign rsp_ch.busy_res   = out_data_ff.busy_res;
   assign rsp_ch.rejected   = out_data_ff.rejected;

endmodule

@@ src/manchester_frame_transmitter_core.sv @@
// ----------------------------------------------------------------------------
// Manchester frame transmitter core
// Buffers payload bytes and serializes framed Manchester words onto a line.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock cycle and returns exactly
// one response transaction for each through a two-entry output buffer, an
// output register plus a skid entry; it only stalls when that buffer is full.
// Payload bytes sit in a memory with a registered read. The memory is read
// continuously at the current frame position, and since a word boundary comes
// at most once per twenty ticks, the next payload byte is always ready when
// it is needed. The store needs no clearing pass after reset: only bytes
// appended for the current frame are ever sent. Configuration writes should
// be made while no frame is being sent.
module manchester_frame_transmitter_core #(
   parameter int unsigned FRAME_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   mfx_req_if.sink    req_ch,
   mfx_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import mfx_pkg::*;

   localparam int unsigned ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int unsigned LEN_W  = $clog2(FRAME_DEPTH + FRAME_OVERHEAD + 1);

   // Configuration registers.
   logic [BYTE_W-1:0] sync_ff, start_flag_ff, end_flag_ff;

   // Transmitter state.
   logic [HALF_BITS_PER_WORD-1:0] shift_ff, shift_in;
   logic [HALF_CNT_W-1:0]         half_ff, half_in;
   logic [LEN_W-1:0]              pos_ff, pos_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic                          sending_ff, sending_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          level_ff, level_in;

   logic                  accept;
   logic                  push_ready;
   logic                  rejected;
   logic                  wr_en;
   logic [BYTE_W-1:0]     rd_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [LEN_W-1:0]      pos_next;
   logic [HALF_CNT_W-1:0] half_dec;
   logic [BYTE_W-1:0]     frame_byte;
   rsp_payload_type       rsp_data;

   assign accept       = req_ch.valid && push_ready;
   assign req_ch.ready = push_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= '0;
         start_flag_ff <= '0;
         end_flag_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC:       sync_ff       <= csr_wdata;
            CSR_START_FLAG: start_flag_ff <= csr_wdata;
            CSR_END_FLAG:   end_flag_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Payload memory, read at the payload slot of the current frame position.
   assign rd_addr = ADDR_W'(pos_ff - LEN_W'(POS_PAYLOAD));

   mfx_store #(
      .DEPTH  (FRAME_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_ch.payload_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Selection of the frame byte at the current position.
   assign pos_next = pos_ff + LEN_W'(1);

   always_comb begin
      if (pos_ff < LEN_W'(POS_SYNC)) begin
         frame_byte = PREAMBLE_BYTE;
      end else if (pos_ff == LEN_W'(POS_SYNC)) begin
         frame_byte = sync_ff;
      end else if (pos_ff == LEN_W'(POS_START_FLAG)) begin
         frame_byte = start_flag_ff;
      end else if (pos_next < len_ff) begin
         frame_byte = rd_data;
      end else begin
         frame_byte = end_flag_ff;
      end
   end

   assign half_dec = (half_ff != '0) ? half_ff - HALF_CNT_W'(1) : half_ff;

   // Request handling and the half-bit serializer.
   always_comb begin
      shift_in   = shift_ff;
      half_in    = half_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      sending_in = sending_ff;
      count_in   = count_ff;
      level_in   = level_ff;
      rejected   = 1'b0;
      wr_en      = 1'b0;
      if (accept) begin
         case (req_ch.req_type)
            REQ_APPEND: begin
               if (sending_ff || count_ff >= CNT_W'(FRAME_DEPTH)) begin
                  rejected = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_START: begin
               if (sending_ff) begin
                  rejected = 1'b1;
               end else begin
                  len_in     = LEN_W'(count_ff) + LEN_W'(FRAME_OVERHEAD);
                  pos_in     = '0;
                  count_in   = '0;
                  sending_in = 1'b1;
               end
            end
            REQ_TICK: begin
               level_in = shift_ff[0];
               shift_in = shift_ff >> 1;
               half_in  = half_dec;
               if (half_dec == '0) begin
                  shift_in = IDLE_WORD;
                  if (sending_ff) begin
                     if (pos_ff < len_ff) begin
                        shift_in = encode_word(frame_byte);
                        pos_in   = pos_next;
                     end else begin
                        sending_in = 1'b0;
                        pos_in     = '0;
                        len_in     = '0;
                     end
                  end
                  half_in = HALF_CNT_W'(HALF_BITS_PER_WORD);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= ONES_WORD;
         half_ff    <= HALF_CNT_W'(HALF_BITS_PER_WORD);
         pos_ff     <= '0;
         len_ff     <= '0;
         sending_ff <= 1'b0;
         count_ff   <= '0;
         level_ff   <= 1'b1;
      end else begin
         shift_ff   <= shift_in;
         half_ff    <= half_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         sending_ff <= sending_in;
         count_ff   <= count_in;
         level_ff   <= level_in;
      end
   end

   // Response for this transaction.
   assign rsp_data.line_level = level_in;
   assign rsp_data.busy_res   = sending_in;
   assign rsp_data.rejected   = rejected;

   mfx_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (rsp_data),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
